// ===== sv/utf8d_pkg.sv =====
// utf8d_pkg: widths, sequence length codes and shared structs for the utf-8 decoder
// no dependencies; used by utf8d_step, utf8_stream_decoder and tb
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    // field widths
    localparam int CP_WIDTH    = 31;
    localparam int IDX_WIDTH   = 16;
    localparam int BYTE_WIDTH  = 8;
    localparam int LEFT_WIDTH  = 3;

    // saturating character counter width, 8 to 32
    localparam int COUNT_WIDTH = 16;
    localparam int CNT_EXT_W   = (COUNT_WIDTH > IDX_WIDTH) ? COUNT_WIDTH : IDX_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [IDX_WIDTH-1:0]   IDX_MAX = {IDX_WIDTH{1'b1}};

    // largest latin-1 code point
    localparam logic [CP_WIDTH-1:0] LATIN1_MAX = CP_WIDTH'(255);

    // continuation bytes still expected after a lead byte
    localparam logic [LEFT_WIDTH-1:0] LEFT_NONE = 3'd0;
    localparam logic [LEFT_WIDTH-1:0] LEFT_LAST = 3'd1;
    localparam logic [LEFT_WIDTH-1:0] LEFT_TWO  = 3'd1;
    localparam logic [LEFT_WIDTH-1:0] LEFT_THR  = 3'd2;
    localparam logic [LEFT_WIDTH-1:0] LEFT_FOUR = 3'd3;
    localparam logic [LEFT_WIDTH-1:0] LEFT_FIVE = 3'd4;
    localparam logic [LEFT_WIDTH-1:0] LEFT_SIX  = 3'd5;

    // decoder state carried between bytes
    typedef struct packed {
        logic [CP_WIDTH-1:0]    partial_code;
        logic [LEFT_WIDTH-1:0]  bytes_left;
        logic [COUNT_WIDTH-1:0] char_counter;
        logic                   latin1_so_far;
    } state_t;

    // one decoded character
    typedef struct packed {
        logic                 emit;
        logic [CP_WIDTH-1:0]  code_point;
        logic [IDX_WIDTH-1:0] char_index;
        logic                 all_latin1;
        logic                 stray_byte;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/utf8d_step.sv =====
// utf8d_step: next-state and result logic for one byte of the utf-8 stream
// depends on utf8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
    input  wire utf8d_pkg::state_t                   state_i,
    input  wire logic [utf8d_pkg::BYTE_WIDTH-1:0]    data_byte,
    input  wire logic                                first_of_string,
    output utf8d_pkg::state_t                        state_o,
    output utf8d_pkg::result_t                       result_o
);

    logic [utf8d_pkg::COUNT_WIDTH-1:0] count_base;
    logic                              latin_base;
    logic [utf8d_pkg::COUNT_WIDTH-1:0] count_new;
    logic [utf8d_pkg::CNT_EXT_W-1:0]   count_ext;
    logic [utf8d_pkg::CP_WIDTH-1:0]    cp;
    logic [utf8d_pkg::CP_WIDTH-1:0]    partial_next;
    logic [utf8d_pkg::LEFT_WIDTH-1:0]  left_next;
    logic                              emit;
    logic                              stray;

    // sequence decode
    always_comb begin
        partial_next  = state_i.partial_code;
        left_next     = state_i.bytes_left;
        emit          = 1'b0;
        stray         = 1'b0;
        cp            = '0;
        if (state_i.bytes_left != utf8d_pkg::LEFT_NONE) begin
            // any byte counts as a continuation, low six bits appended
            partial_next = {state_i.partial_code[utf8d_pkg::CP_WIDTH-7:0], data_byte[5:0]};
            left_next    = state_i.bytes_left - 3'd1;
            emit         = (state_i.bytes_left == utf8d_pkg::LEFT_LAST);
            cp           = partial_next;
        end else begin
            priority casez (data_byte)
                8'b0???_????: begin
                    emit = 1'b1;
                    cp   = utf8d_pkg::CP_WIDTH'(data_byte);
                end
                8'b10??_????: begin
                    emit  = 1'b1;
                    stray = 1'b1;
                    cp    = utf8d_pkg::CP_WIDTH'(data_byte);
                end
                8'b110?_????: begin
                    partial_next = utf8d_pkg::CP_WIDTH'(data_byte[4:0]);
                    left_next    = utf8d_pkg::LEFT_TWO;
                end
                8'b1110_????: begin
                    partial_next = utf8d_pkg::CP_WIDTH'(data_byte[3:0]);
                    left_next    = utf8d_pkg::LEFT_THR;
                end
                8'b1111_0???: begin
                    partial_next = utf8d_pkg::CP_WIDTH'(data_byte[2:0]);
                    left_next    = utf8d_pkg::LEFT_FOUR;
                end
                8'b1111_10??: begin
                    partial_next = utf8d_pkg::CP_WIDTH'(data_byte[1:0]);
                    left_next    = utf8d_pkg::LEFT_FIVE;
                end
                default: begin
                    // 0xfc to 0xff: six-byte lead, one payload bit
                    partial_next = utf8d_pkg::CP_WIDTH'(data_byte[0]);
                    left_next    = utf8d_pkg::LEFT_SIX;
                end
            endcase
        end
    end

    // string counters, cleared by first_of_string before this byte
    always_comb begin
        count_base = first_of_string ? '0 : state_i.char_counter;
        latin_base = first_of_string ? 1'b1 : state_i.latin1_so_far;
        count_new  = (count_base == utf8d_pkg::CNT_MAX) ? count_base
                                                         : count_base + 1'b1;
        count_ext  = utf8d_pkg::CNT_EXT_W'(count_new);

        state_o.partial_code  = partial_next;
        state_o.bytes_left    = left_next;
        state_o.char_counter  = count_base;
        state_o.latin1_so_far = latin_base;
        if (emit) begin
            state_o.char_counter  = count_new;
            state_o.latin1_so_far = latin_base & (cp <= utf8d_pkg::LATIN1_MAX);
        end

        result_o.emit       = emit;
        result_o.code_point = cp;
        result_o.all_latin1 = state_o.latin1_so_far;
        result_o.stray_byte = stray;
        if (count_ext > utf8d_pkg::CNT_EXT_W'(utf8d_pkg::IDX_MAX)) begin
            result_o.char_index = utf8d_pkg::IDX_MAX;
        end else begin
            result_o.char_index = count_ext[utf8d_pkg::IDX_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8_stream_decoder.sv =====
// utf8_stream_decoder: byte-serial utf-8 decoder, legacy sequences of up to six bytes
// depends on utf8d_pkg and utf8d_step
// a completed character appears on m_ in the cycle after its last byte transfer
// throughput: one byte per cycle while s_ready is high; the state register closes the per-byte loop
// lead bytes and non-final continuation bytes give no result; the byte stream is taken whenever the
// output register is empty or being drained
// reset clears the partial code point, byte count, character count and output valid,
// and sets the latin-1 flag
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [utf8d_pkg::BYTE_WIDTH-1:0]   s_data_byte,
    input  wire logic                               s_first_of_string,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [utf8d_pkg::CP_WIDTH-1:0]          m_code_point,
    output logic [utf8d_pkg::IDX_WIDTH-1:0]         m_char_index,
    output logic                                    m_all_latin1,
    output logic                                    m_stray_byte
);

    utf8d_pkg::state_t  state_reg;
    utf8d_pkg::state_t  state_next;
    utf8d_pkg::result_t step_result;

    logic                              m_valid_reg;
    logic [utf8d_pkg::CP_WIDTH-1:0]    code_point_reg;
    logic [utf8d_pkg::IDX_WIDTH-1:0]   char_index_reg;
    logic                              all_latin1_reg;
    logic                              stray_byte_reg;
    logic                              s_fire;

    // accept while the output register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    utf8d_step u_step (
        .state_i         (state_reg),
        .data_byte       (s_data_byte),
        .first_of_string (s_first_of_string),
        .state_o         (state_next),
        .result_o        (step_result)
    );

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.partial_code  <= '0;
            state_reg.bytes_left    <= utf8d_pkg::LEFT_NONE;
            state_reg.char_counter  <= '0;
            state_reg.latin1_so_far <= 1'b1;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && step_result.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_fire && step_result.emit) begin
            code_point_reg <= step_result.code_point;
            char_index_reg <= step_result.char_index;
            all_latin1_reg <= step_result.all_latin1;
            stray_byte_reg <= step_result.stray_byte;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = code_point_reg;
    assign m_char_index = char_index_reg;
    assign m_all_latin1 = all_latin1_reg;
    assign m_stray_byte = stray_byte_reg;

    // an empty output register never blocks the byte stream
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("s_ready low with empty output register");

    // a lead byte taken between sequences opens a sequence
    a_lead_opens_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_reg.bytes_left == utf8d_pkg::LEFT_NONE && s_data_byte >= 8'hC0)
        |=> (state_reg.bytes_left != utf8d_pkg::LEFT_NONE) && !m_valid_reg
            || (state_reg.bytes_left != utf8d_pkg::LEFT_NONE))
        else $error("lead byte did not start a sequence");

    // first character of a string reports index one
    a_first_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_first_of_string && step_result.emit)
        |=> m_valid && m_char_index == utf8d_pkg::IDX_WIDTH'(1))
        else $error("first character of string not at index one");

    // a stray result carries a continuation byte value
    a_stray_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stray_byte)
        |-> (m_code_point >= utf8d_pkg::CP_WIDTH'(8'h80)
             && m_code_point <= utf8d_pkg::CP_WIDTH'(8'hBF)))
        else $error("stray transfer outside continuation range");

    // a byte that leaves a sequence open gives no result
    a_no_emit_mid_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_next.bytes_left != utf8d_pkg::LEFT_NONE) |-> !step_result.emit)
        else $error("result emitted with sequence still open");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for utf8_stream_decoder, driving a byte stream and
// predicting each decoded character; depends on utf8d_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb;

    // byte class boundaries of the legacy six-byte scheme
    localparam logic [utf8d_pkg::BYTE_WIDTH-1:0] CONT_BASE  = 8'h80;
    localparam logic [utf8d_pkg::BYTE_WIDTH-1:0] LEAD2_BASE = 8'hC0;
    localparam logic [utf8d_pkg::BYTE_WIDTH-1:0] LEAD3_BASE = 8'hE0;
    localparam logic [utf8d_pkg::BYTE_WIDTH-1:0] LEAD4_BASE = 8'hF0;
    localparam logic [utf8d_pkg::BYTE_WIDTH-1:0] LEAD5_BASE = 8'hF8;
    localparam logic [utf8d_pkg::BYTE_WIDTH-1:0] LEAD6_BASE = 8'hFC;

    localparam int RANDOM_BYTES = 1650;
    localparam int COUNT_BYTES  = 40;
    localparam int HOLD_OFF     = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [utf8d_pkg::CP_WIDTH-1:0]  code_point;
        logic [utf8d_pkg::IDX_WIDTH-1:0] char_index;
        logic                            all_latin1;
        logic                            stray_byte;
    } char_t;

    typedef struct packed {
        logic [utf8d_pkg::BYTE_WIDTH-1:0] value;
        logic                             first;
    } stream_byte_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [utf8d_pkg::BYTE_WIDTH-1:0] s_data_byte = '0;
    logic                             s_first_of_string = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [utf8d_pkg::CP_WIDTH-1:0]   m_code_point;
    logic [utf8d_pkg::IDX_WIDTH-1:0]  m_char_index;
    logic                             m_all_latin1;
    logic                             m_stray_byte;

    // decoder state as predicted from the accepted bytes
    logic [utf8d_pkg::CP_WIDTH-1:0]    dec_partial = '0;
    logic [utf8d_pkg::LEFT_WIDTH-1:0]  dec_left = utf8d_pkg::LEFT_NONE;
    logic [utf8d_pkg::COUNT_WIDTH-1:0] dec_count = '0;
    logic                              dec_latin1 = 1'b1;

    char_t        expected_chars[$];
    stream_byte_t byte_plan[$];
    int           error_count = 0;

    // receiver stall control
    int   rx_stall_pct = 0;
    int   rx_hold_request = 0;
    int   rx_hold_left = 0;
    int   rx_run_left = 0;
    logic rx_run_stall = 1'b0;

    utf8_stream_decoder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_first_of_string (s_first_of_string),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_code_point      (m_code_point),
        .m_char_index      (m_char_index),
        .m_all_latin1      (m_all_latin1),
        .m_stray_byte      (m_stray_byte)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // a completed character bumps the saturating count and may clear latin-1
    function automatic void record_char(input logic [utf8d_pkg::CP_WIDTH-1:0] cp,
                                        input logic stray);
        char_t c;
        if (dec_count != utf8d_pkg::CNT_MAX) begin
            dec_count = dec_count + 1'b1;
        end
        if (cp > utf8d_pkg::LATIN1_MAX) begin
            dec_latin1 = 1'b0;
        end
        c.code_point = cp;
        c.char_index = (utf8d_pkg::CNT_EXT_W'(dec_count) >
                        utf8d_pkg::CNT_EXT_W'(utf8d_pkg::IDX_MAX)) ?
                       utf8d_pkg::IDX_MAX : utf8d_pkg::IDX_WIDTH'(dec_count);
        c.all_latin1 = dec_latin1;
        c.stray_byte = stray;
        expected_chars.push_back(c);
    endfunction

    function automatic void decode_byte(input logic [utf8d_pkg::BYTE_WIDTH-1:0] b,
                                        input logic first);
        if (first) begin
            dec_count  = '0;
            dec_latin1 = 1'b1;
        end
        // any byte continues a sequence in progress, unchecked
        if (dec_left != utf8d_pkg::LEFT_NONE) begin
            dec_partial = {dec_partial[utf8d_pkg::CP_WIDTH-7:0], b[5:0]};
            dec_left    = dec_left - 1'b1;
            if (dec_left == utf8d_pkg::LEFT_NONE) begin
                record_char(dec_partial, 1'b0);
            end
        end else if (b < CONT_BASE) begin
            record_char(utf8d_pkg::CP_WIDTH'(b), 1'b0);
        end else if (b < LEAD2_BASE) begin
            record_char(utf8d_pkg::CP_WIDTH'(b), 1'b1);
        end else if (b < LEAD3_BASE) begin
            dec_partial = utf8d_pkg::CP_WIDTH'(b[4:0]);
            dec_left    = utf8d_pkg::LEFT_TWO;
        end else if (b < LEAD4_BASE) begin
            dec_partial = utf8d_pkg::CP_WIDTH'(b[3:0]);
            dec_left    = utf8d_pkg::LEFT_THR;
        end else if (b < LEAD5_BASE) begin
            dec_partial = utf8d_pkg::CP_WIDTH'(b[2:0]);
            dec_left    = utf8d_pkg::LEFT_FOUR;
        end else if (b < LEAD6_BASE) begin
            dec_partial = utf8d_pkg::CP_WIDTH'(b[1:0]);
            dec_left    = utf8d_pkg::LEFT_FIVE;
        end else begin
            dec_partial = utf8d_pkg::CP_WIDTH'(b[0]);
            dec_left    = utf8d_pkg::LEFT_SIX;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // compare each output transfer, then predict from each input transfer
    always @(posedge aclk) begin : char_checker
        char_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character", 32'(m_code_point), '0);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_code_point !== want.code_point)
                        report_mismatch("code_point", 32'(m_code_point), 32'(want.code_point));
                    if (m_char_index !== want.char_index)
                        report_mismatch("char_index", 32'(m_char_index), 32'(want.char_index));
                    if (m_all_latin1 !== want.all_latin1)
                        report_mismatch("all_latin1", 32'(m_all_latin1), 32'(want.all_latin1));
                    if (m_stray_byte !== want.stray_byte)
                        report_mismatch("stray_byte", 32'(m_stray_byte), 32'(want.stray_byte));
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_first_of_string);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: runs of ready or stall, plus an optional long hold-off
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : receiver
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_run_left == 0) begin
                rx_run_left  = $urandom_range(1, 12);
                rx_run_stall = ($urandom_range(0, 99) < rx_stall_pct);
            end
            rx_run_left--;
            m_ready <= !rx_run_stall;
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one byte and return at the edge of its transfer, valid left high
    task automatic send_byte(input logic [utf8d_pkg::BYTE_WIDTH-1:0] b, input logic first);
        s_valid           <= 1'b1;
        s_data_byte       <= b;
        s_first_of_string <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // hold the input idle until every predicted character has been taken
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // random sequence building
    // ------------------------------------------------------------------

    function automatic void plan_byte(input logic [utf8d_pkg::BYTE_WIDTH-1:0] b);
        stream_byte_t sb;
        sb.value = b;
        sb.first = ($urandom_range(0, 39) == 0);
        byte_plan.push_back(sb);
    endfunction

    function automatic logic [utf8d_pkg::BYTE_WIDTH-1:0] lead_byte(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            4:       return {5'b11110, 3'($urandom)};
            5:       return {6'b111110, 2'($urandom)};
            default: return {6'b111111, 2'($urandom)};
        endcase
    endfunction

    // mostly well-formed continuation bytes, now and then an arbitrary one
    function automatic logic [utf8d_pkg::BYTE_WIDTH-1:0] cont_byte();
        if ($urandom_range(0, 15) == 0) begin
            return 8'($urandom);
        end
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic void plan_sequence();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 28) begin
            plan_byte(8'($urandom_range(0, 127)));
        end else if (kind < 84) begin
            len = (kind < 48) ? 2 : (kind < 62) ? 3 : (kind < 72) ? 4 : (kind < 78) ? 5 : 6;
            plan_byte(lead_byte(len));
            repeat (len - 1) plan_byte(cont_byte());
        end else if (kind < 90) begin
            // stray continuation byte
            plan_byte({2'b10, 6'($urandom)});
        end else if (kind < 95) begin
            // cut-short sequence, the next lead gets swallowed
            len = $urandom_range(2, 6);
            plan_byte(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) plan_byte(cont_byte());
        end else begin
            repeat ($urandom_range(1, 4)) plan_byte(8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // ascii extremes and stray continuation extremes
    task automatic test_ascii_and_stray();
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    // two-, three-, five- and six-byte sequences, latin-1 kept then lost, largest code point
    task automatic test_lead_classes();
        send_byte(8'hC2, 1'b1);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hFB, 1'b0);
        repeat (4) send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
    endtask

    // zero and lead bytes taken as continuation, new string inside a sequence
    task automatic test_odd_sequences();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h80, 1'b0);
    endtask

    // character count climbs through a string, then a new string restarts it
    task automatic test_count_restart();
        rx_stall_pct = 0;
        for (int i = 0; i < COUNT_BYTES; i++) begin
            send_byte(8'h41 + 8'(i % 26), i == 0);
        end
        send_byte(8'h20, 1'b1);
        wait_for_drain();
    endtask

    // receiver holds off while bytes keep coming, then the sender waits it out
    task automatic test_backpressure();
        stream_byte_t sb;
        rx_stall_pct    = 0;
        rx_hold_request = HOLD_OFF;
        repeat (16) plan_sequence();
        while (byte_plan.size() != 0) begin
            sb = byte_plan.pop_front();
            send_byte(sb.value, sb.first);
        end
        wait_for_drain();
    endtask

    // random stream in bursts, receiver stall density stepped up per segment, random in the last
    task automatic test_random_stream(input int n_bytes);
        int           sent;
        int           burst_left;
        int           seg;
        stream_byte_t sb;
        sent       = 0;
        burst_left = 0;
        while (sent < n_bytes) begin
            seg = sent * 5 / n_bytes;
            case (seg)
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 20;
                2:       rx_stall_pct = 50;
                3:       rx_stall_pct = 80;
                default: rx_stall_pct = $urandom_range(0, 90);
            endcase
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (seg != 0) begin
                    pause_sender($urandom_range(0, 8));
                end
            end
            if (byte_plan.size() == 0) begin
                plan_sequence();
            end
            sb = byte_plan.pop_front();
            send_byte(sb.value, sb.first);
            burst_left--;
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_ascii_and_stray();
        test_lead_classes();
        test_odd_sequences();
        test_count_restart();
        test_backpressure();
        test_random_stream(RANDOM_BYTES);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
